[rtl/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge out of reset
`define TESQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// antecedent implies consequent in the next clock cycle
`define TESQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/tesq_pkg.sv]
// ----------------------------------------------------------------------------
// tesq_pkg
// types and constants of the timed event sorted queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tesq_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int MAX_RESULTS = 16;
    localparam int K_W         = $clog2(MAX_RESULTS + 1);
    localparam int TIME_W      = 32;
    localparam int PIN_W       = 8;
    localparam int ACT_W       = 2;
    localparam int POS_W       = 4;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_TICK   = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_NONE  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_CHK,
        S_ADD_CMP,
        S_REM_CHK,
        S_REM_CMP,
        S_READ_OUT,
        S_TICK_CHK,
        S_TICK_CMP,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [TIME_W-1:0] time_val;
        logic [PIN_W-1:0]  pin;
        logic [ACT_W-1:0]  action;
    } entry_t;

endpackage

[rtl/tesq_mem.sv]
// ----------------------------------------------------------------------------
// tesq_mem
// event slot memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tesq_mem
    import tesq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data
);

    entry_t slot_mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/timed_event_sorted_queue.sv]
// ----------------------------------------------------------------------------
// timed_event_sorted_queue
// time-ordered store of pending pin events in a circular slot memory
// ----------------------------------------------------------------------------
//  channel | handshake           | beat contents
//  in      | in_valid, in_stall  | operation, event_time, pin_number, pin_action,
//          |                     | position, now_time
//  out     | out_valid, out_stall| status, out_pin, out_action, out_time,
//          |                     | entry_count, last
//
//  state walk from the accepting cycle to the last result beat, shaped by the
//  slot memory with one write port and a registered read; add: S_ADD_CHK and
//  S_ADD_CMP in turn, one pair per entry moved up, then S_RESP; when full, S_RESP
//  remove: S_REM_CHK and S_REM_CMP in turn per entry moved down, then S_RESP;
//  position zero or out of range goes straight to S_RESP
//  read: S_READ_OUT; tick: S_TICK_CHK and S_TICK_CMP in turn per popped entry
//  reset clears state, count, head, k, have and out_valid, no clearing pass;
//  out_stall holds the sequencer only where it has a beat to hand over
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module timed_event_sorted_queue
    import tesq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int CW    = $clog2(DEPTH + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        operation,
    input  logic [TIME_W-1:0] event_time,
    input  logic [PIN_W-1:0]  pin_number,
    input  logic [ACT_W-1:0]  pin_action,
    input  logic [POS_W-1:0]  position,
    input  logic [TIME_W-1:0] now_time,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        status,
    output logic [PIN_W-1:0]  out_pin,
    output logic [ACT_W-1:0]  out_action,
    output logic [TIME_W-1:0] out_time,
    output logic [CW-1:0]     entry_count,
    output logic              last
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW = ((AW > CW) ? AW : CW) + 1;
    localparam int LW = (CW > POS_W) ? CW : POS_W;

    state_t            state_reg, state_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [K_W-1:0]    k_reg, k_next;
    logic              have_reg, have_next;
    entry_t            hold_reg, hold_next;
    logic [TIME_W-1:0] t_reg, t_next;
    logic [PIN_W-1:0]  pin_reg, pin_next;
    logic [ACT_W-1:0]  act_reg, act_next;
    logic [TIME_W-1:0] now_reg, now_next;
    status_t           st_reg, st_next;

    logic              out_valid_reg, out_valid_next;
    status_t           status_reg, status_next;
    logic [PIN_W-1:0]  out_pin_reg, out_pin_next;
    logic [ACT_W-1:0]  out_action_reg, out_action_next;
    logic [TIME_W-1:0] out_time_reg, out_time_next;
    logic [CW-1:0]     entry_count_reg, entry_count_next;
    logic              last_reg, last_next;

    logic              wr_en, rd_en;
    logic [AW-1:0]     wr_addr, rd_addr;
    entry_t            wr_data, rd_data, new_ent;

    logic can_emit, is_full, pos_out, idx_zero, rem_more, tick_more, due, move_up;
    logic [AW-1:0] head_inc;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                           input logic [CW-1:0] off);
        logic [PW-1:0] sum;
        sum = PW'(base) + PW'(off);
        if (sum >= PW'(DEPTH))
        begin
            sum = sum - PW'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    tesq_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign new_ent   = '{time_val: t_reg, pin: pin_reg, action: act_reg};
    assign can_emit  = !out_valid_reg || !out_stall;
    assign is_full   = (count_reg == CW'(DEPTH));
    assign pos_out   = (LW'(position) >= LW'(count_reg));
    assign idx_zero  = (idx_reg == '0);
    assign rem_more  = ((CW + 1)'(idx_reg) + (CW + 1)'(1)) < (CW + 1)'(count_reg);
    assign tick_more = (count_reg != '0) && (k_reg < K_W'(MAX_RESULTS));
    assign due       = (rd_data.time_val <= now_reg);
    assign move_up   = (rd_data.time_val >= t_reg);
    assign head_inc  = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (op_t'(operation))
                        OP_ADD:    state_next = is_full ? S_RESP : S_ADD_CHK;
                        OP_REMOVE: state_next = (pos_out || position == '0) ? S_RESP
                                                                              : S_REM_CHK;
                        OP_READ:   state_next = pos_out ? S_RESP : S_READ_OUT;
                        OP_TICK:   state_next = S_TICK_CHK;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_ADD_CHK:  state_next = idx_zero ? S_RESP : S_ADD_CMP;
            S_ADD_CMP:  state_next = move_up ? S_ADD_CHK : S_RESP;
            S_REM_CHK:  state_next = rem_more ? S_REM_CMP : S_RESP;
            S_REM_CMP:  state_next = S_REM_CHK;
            S_READ_OUT: state_next = can_emit ? S_IDLE : S_READ_OUT;
            S_TICK_CHK:
            begin
                if (tick_more)
                begin
                    state_next = S_TICK_CMP;
                end
                else if (can_emit)
                begin
                    state_next = S_IDLE;
                end
            end
            S_TICK_CMP:
            begin
                if (!(have_reg || !due) || can_emit)
                begin
                    state_next = due ? S_TICK_CHK : S_IDLE;
                end
            end
            S_RESP:     state_next = can_emit ? S_IDLE : S_RESP;
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        head_next        = head_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        k_next           = k_reg;
        have_next        = have_reg;
        hold_next        = hold_reg;
        t_next           = t_reg;
        pin_next         = pin_reg;
        act_next         = act_reg;
        now_next         = now_reg;
        st_next          = st_reg;
        out_valid_next   = out_valid_reg && out_stall;
        status_next      = status_reg;
        out_pin_next     = out_pin_reg;
        out_action_next  = out_action_reg;
        out_time_next    = out_time_reg;
        entry_count_next = entry_count_reg;
        last_next        = last_reg;
        wr_en            = 1'b0;
        wr_addr          = '0;
        wr_data          = new_ent;
        rd_en            = 1'b0;
        rd_addr          = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    t_next    = event_time;
                    pin_next  = pin_number;
                    act_next  = pin_action;
                    now_next  = now_time;
                    k_next    = '0;
                    have_next = 1'b0;
                    idx_next  = count_reg;
                    st_next   = ST_OK;
                    case (op_t'(operation))
                        OP_ADD:
                        begin
                            if (is_full)
                            begin
                                st_next = ST_FULL;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (pos_out)
                            begin
                                st_next = ST_RANGE;
                            end
                            else if (position == '0)
                            begin
                                head_next  = head_inc;
                                count_next = count_reg - CW'(1);
                            end
                            else
                            begin
                                idx_next = CW'(position);
                            end
                        end
                        OP_READ:
                        begin
                            if (pos_out)
                            begin
                                st_next = ST_RANGE;
                            end
                            else
                            begin
                                rd_en   = 1'b1;
                                rd_addr = phys(head_reg, CW'(position));
                            end
                        end
                        default:
                        begin
                            st_next = ST_OK;
                        end
                    endcase
                end
            end
            S_ADD_CHK:
            begin
                if (idx_zero)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = head_reg;
                    count_next = count_reg + CW'(1);
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = phys(head_reg, idx_reg - CW'(1));
                end
            end
            S_ADD_CMP:
            begin
                wr_en   = 1'b1;
                wr_addr = phys(head_reg, idx_reg);
                if (move_up)
                begin
                    wr_data  = rd_data;
                    idx_next = idx_reg - CW'(1);
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            S_REM_CHK:
            begin
                if (rem_more)
                begin
                    rd_en   = 1'b1;
                    rd_addr = phys(head_reg, idx_reg + CW'(1));
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            S_REM_CMP:
            begin
                wr_en    = 1'b1;
                wr_addr  = phys(head_reg, idx_reg);
                wr_data  = rd_data;
                idx_next = idx_reg + CW'(1);
            end
            S_READ_OUT:
            begin
                if (can_emit)
                begin
                    out_valid_next   = 1'b1;
                    status_next      = ST_OK;
                    out_pin_next     = rd_data.pin;
                    out_action_next  = rd_data.action;
                    out_time_next    = rd_data.time_val;
                    entry_count_next = count_reg;
                    last_next        = 1'b1;
                end
            end
            S_TICK_CHK:
            begin
                if (tick_more)
                begin
                    rd_en   = 1'b1;
                    rd_addr = head_reg;
                end
                else if (can_emit)
                begin
                    out_valid_next   = 1'b1;
                    status_next      = have_reg ? ST_OK : ST_NONE;
                    out_pin_next     = have_reg ? hold_reg.pin : '0;
                    out_action_next  = have_reg ? hold_reg.action : '0;
                    out_time_next    = have_reg ? hold_reg.time_val : '0;
                    entry_count_next = count_reg;
                    last_next        = 1'b1;
                end
            end
            S_TICK_CMP:
            begin
                if (!(have_reg || !due) || can_emit)
                begin
                    if (have_reg || !due)
                    begin
                        out_valid_next   = 1'b1;
                        status_next      = have_reg ? ST_OK : ST_NONE;
                        out_pin_next     = have_reg ? hold_reg.pin : '0;
                        out_action_next  = have_reg ? hold_reg.action : '0;
                        out_time_next    = have_reg ? hold_reg.time_val : '0;
                        entry_count_next = count_reg;
                        last_next        = !due;
                    end
                    if (due)
                    begin
                        hold_next  = rd_data;
                        have_next  = 1'b1;
                        head_next  = head_inc;
                        count_next = count_reg - CW'(1);
                        k_next     = k_reg + K_W'(1);
                    end
                end
            end
            S_RESP:
            begin
                if (can_emit)
                begin
                    out_valid_next   = 1'b1;
                    status_next      = st_reg;
                    out_pin_next     = '0;
                    out_action_next  = '0;
                    out_time_next    = '0;
                    entry_count_next = count_reg;
                    last_next        = 1'b1;
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            k_reg         <= '0;
            have_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            k_reg         <= k_next;
            have_reg      <= have_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        hold_reg        <= hold_next;
        t_reg           <= t_next;
        pin_reg         <= pin_next;
        act_reg         <= act_next;
        now_reg         <= now_next;
        st_reg          <= st_next;
        status_reg      <= status_next;
        out_pin_reg     <= out_pin_next;
        out_action_reg  <= out_action_next;
        out_time_reg    <= out_time_next;
        entry_count_reg <= entry_count_next;
        last_reg        <= last_next;
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign out_pin     = out_pin_reg;
    assign out_action  = out_action_reg;
    assign out_time    = out_time_reg;
    assign entry_count = entry_count_reg;
    assign last        = last_reg;

endmodule

[rtl/tesq_checker.sv]
// ----------------------------------------------------------------------------
// tesq_checker
// port level checks of the timed event sorted queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tesq_checker
    import tesq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int CW    = $clog2(DEPTH + 1)
)
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic [1:0]        operation,
    input logic [TIME_W-1:0] event_time,
    input logic [PIN_W-1:0]  pin_number,
    input logic [ACT_W-1:0]  pin_action,
    input logic [POS_W-1:0]  position,
    input logic [TIME_W-1:0] now_time,
    input logic              out_valid,
    input logic              out_stall,
    input logic [1:0]        status,
    input logic [PIN_W-1:0]  out_pin,
    input logic [ACT_W-1:0]  out_action,
    input logic [TIME_W-1:0] out_time,
    input logic [CW-1:0]     entry_count,
    input logic              last
);

    `TESQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(status) && $stable(last) && $stable(entry_count) && $stable(out_pin) && $stable(out_action) && $stable(out_time))
    `TESQ_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && in_stall,
        in_valid && $stable(operation) && $stable(event_time) && $stable(pin_number) && $stable(pin_action) && $stable(position) && $stable(now_time))
    `TESQ_ASSERT(a_count_range, clk, rst_n, out_valid |-> entry_count <= CW'(DEPTH))
    `TESQ_ASSERT(a_full_count, clk, rst_n,
        (out_valid && status == ST_FULL) |-> (entry_count == CW'(DEPTH) && last))
    `TESQ_ASSERT(a_error_last, clk, rst_n,
        (out_valid && (status == ST_RANGE || status == ST_NONE)) |-> last)

endmodule

bind timed_event_sorted_queue tesq_checker #(.DEPTH(DEPTH), .CW(CW)) u_tesq_checker (.*);

[tb/tb_timed_event_sorted_queue.sv]
// ----------------------------------------------------------------------------
// tb_timed_event_sorted_queue
// self-checking bench for the timed event sorted queue: directed and random
// add, remove, read and tick beats under several idling phases, with results
// predicted by a sorted-list model and compared field by field in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_timed_event_sorted_queue;
    import tesq_pkg::*;

    typedef struct packed {
        logic [1:0]        st;
        logic [PIN_W-1:0]  pin;
        logic [ACT_W-1:0]  act;
        logic [TIME_W-1:0] tm;
        logic [4:0]        cnt;
        logic              lst;
    } event_result_t;

    class event_queue_board;
        entry_t        slots[$];
        event_result_t pending_results[$];
        int            errors;

        function void note_beat(op_t op, logic [TIME_W-1:0] et, logic [PIN_W-1:0] pn,
                                logic [ACT_W-1:0] pa, logic [POS_W-1:0] pos,
                                logic [TIME_W-1:0] now);
            event_result_t r;
            entry_t        e;
            int            p;
            int            k;
            r = '0;
            r.lst = 1'b1;
            case (op)
                OP_ADD:
                begin
                    if (slots.size() >= DEPTH_DEF)
                        r.st = ST_FULL;
                    else
                    begin
                        p = 0;
                        while (p < slots.size() && slots[p].time_val < et)
                            p++;
                        e.time_val = et;
                        e.pin = pn;
                        e.action = pa;
                        slots.insert(p, e);
                        r.st = ST_OK;
                    end
                    r.cnt = slots.size();
                    pending_results.push_back(r);
                end
                OP_REMOVE, OP_READ:
                begin
                    if (pos >= slots.size())
                        r.st = ST_RANGE;
                    else if (op == OP_READ)
                    begin
                        r.st = ST_OK;
                        r.pin = slots[pos].pin;
                        r.act = slots[pos].action;
                        r.tm = slots[pos].time_val;
                    end
                    else
                    begin
                        slots.delete(pos);
                        r.st = ST_OK;
                    end
                    r.cnt = slots.size();
                    pending_results.push_back(r);
                end
                default:
                begin
                    k = 0;
                    while (k < MAX_RESULTS && slots.size() > 0 && slots[0].time_val <= now)
                    begin
                        e = slots.pop_front();
                        r.st = ST_OK;
                        r.pin = e.pin;
                        r.act = e.action;
                        r.tm = e.time_val;
                        r.cnt = slots.size();
                        k++;
                        r.lst = !((k < MAX_RESULTS) && slots.size() > 0
                                  && slots[0].time_val <= now);
                        pending_results.push_back(r);
                    end
                    if (k == 0)
                    begin
                        r.st = ST_NONE;
                        r.cnt = slots.size();
                        pending_results.push_back(r);
                    end
                end
            endcase
        endfunction

        function void check_beat(event_result_t got);
            event_result_t want;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $realtime, got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.st !== want.st)
                $display("%0t: status exp %0d got %0d", $realtime, want.st, got.st);
            if (got.pin !== want.pin)
                $display("%0t: out_pin exp %0d got %0d", $realtime, want.pin, got.pin);
            if (got.act !== want.act)
                $display("%0t: out_action exp %0d got %0d", $realtime, want.act, got.act);
            if (got.tm !== want.tm)
                $display("%0t: out_time exp %0h got %0h", $realtime, want.tm, got.tm);
            if (got.cnt !== want.cnt)
                $display("%0t: entry_count exp %0d got %0d", $realtime, want.cnt, got.cnt);
            if (got.lst !== want.lst)
                $display("%0t: last exp %0d got %0d", $realtime, want.lst, got.lst);
            if (got !== want)
                errors++;
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [1:0]        operation;
    logic [TIME_W-1:0] event_time;
    logic [PIN_W-1:0]  pin_number;
    logic [ACT_W-1:0]  pin_action;
    logic [POS_W-1:0]  position;
    logic [TIME_W-1:0] now_time;
    logic              out_valid;
    logic              out_stall;
    logic [1:0]        status;
    logic [PIN_W-1:0]  out_pin;
    logic [ACT_W-1:0]  out_action;
    logic [TIME_W-1:0] out_time;
    logic [4:0]        entry_count;
    logic              last;

    event_queue_board board;
    int               send_idle_pct;
    int               stall_pct;
    int               hold_cycles;
    logic [TIME_W-1:0] base_time;

    timed_event_sorted_queue uut (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // receiver side: random stall plus long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b1;
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_beat({status, out_pin, out_action, out_time, entry_count, last});
    end

    task automatic send_beat(op_t op, logic [TIME_W-1:0] et, logic [PIN_W-1:0] pn,
                             logic [ACT_W-1:0] pa, logic [POS_W-1:0] pos,
                             logic [TIME_W-1:0] now);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        event_time <= et;
        pin_number <= pn;
        pin_action <= pa;
        position <= pos;
        now_time <= now;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_beat(op, et, pn, pa, pos, now);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending_results.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic random_beat;
        int  sel;
        op_t op;
        sel = $urandom_range(99);
        op = sel < 40 ? OP_ADD : sel < 55 ? OP_REMOVE : sel < 80 ? OP_TICK : OP_READ;
        if ($urandom_range(9) == 0)
            send_beat(op, $urandom, $urandom, $urandom, $urandom, $urandom);
        else
        begin
            base_time += (op == OP_TICK) ? $urandom_range(40) : 0;
            send_beat(op, base_time + $urandom_range(60), $urandom, $urandom,
                      $urandom_range(board.slots.size() + 1), base_time);
        end
    endtask

    initial
    begin
        board = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = '0;
        event_time = '0;
        pin_number = '0;
        pin_action = '0;
        position = '0;
        now_time = '0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_cycles = 0;
        base_time = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty cases, extremes, full table, tick cap, ties
        send_beat(OP_TICK, 0, 0, 0, 0, 32'hFFFF_FFFF);
        send_beat(OP_READ, 0, 0, 0, 0, 0);
        send_beat(OP_REMOVE, 0, 0, 0, 15, 0);
        send_beat(OP_ADD, 32'hFFFF_FFFF, 8'hFF, 2'd3, 0, 0);
        send_beat(OP_ADD, 0, 8'h00, 2'd0, 0, 0);
        send_beat(OP_ADD, 0, 8'hA5, 2'd2, 0, 0);
        send_beat(OP_READ, 0, 0, 0, 0, 0);
        send_beat(OP_READ, 0, 0, 0, 2, 0);
        send_beat(OP_READ, 0, 0, 0, 3, 0);
        send_beat(OP_REMOVE, 0, 0, 0, 1, 0);
        send_beat(OP_TICK, 0, 0, 0, 0, 0);
        for (int i = 0; i < 16; i++)
            send_beat(OP_ADD, 100 + (i % 4), i, i % 3, 0, 0);
        send_beat(OP_ADD, 5, 8'h5A, 2'd1, 0, 0);
        send_beat(OP_READ, 0, 0, 0, 15, 0);
        send_beat(OP_TICK, 0, 0, 0, 0, 32'hFFFF_FFFF);
        send_beat(OP_TICK, 0, 0, 0, 0, 32'hFFFF_FFFF);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 86 : 21) : 0;
            stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 86 : 21) : 0;
            if (ph == 0)
                hold_cycles = 400;
            for (int n = 0; n < 65; n++)
                random_beat();
            drain();
        end

        if (board.errors == 0 && board.pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
